>>> hdl/centered_text_glyph_blitter_defines.svh
// Assertion macros for the centered text glyph blitter checker
`ifndef CENTERED_TEXT_GLYPH_BLITTER_DEFINES_SVH
`define CENTERED_TEXT_GLYPH_BLITTER_DEFINES_SVH
// assert that an antecedent implies a consequent on the next clock
`define CTGB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
// assert that a condition never holds
`define CTGB_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`endif

>>> hdl/ctgb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctgb_pkg
// Shared constants and command/status types of the text glyph blitter.
// ----------------------------------------------------------------------------
package ctgb_pkg;
  localparam int FontHeight = 11;
  localparam int FrameDim   = 128;
  localparam int LineChars  = 64;
  localparam int NumGlyphs  = 91;
  localparam int GlyphBytes = FontHeight + 1;
  localparam int FontBytes  = NumGlyphs * GlyphBytes;
  localparam int RowBytes   = (FrameDim + 7) / 8;
  localparam int FrameBytes = RowBytes * FrameDim;
  localparam int FirstCode  = 32;
  localparam int NewlineCode = 10;
  localparam int WidthMax   = 16383;
  localparam int CursorMax  = 255;

  localparam logic [2:0] OP_LOAD  = 3'd0;
  localparam logic [2:0] OP_CLEAR = 3'd1;
  localparam logic [2:0] OP_CHAR  = 3'd2;
  localparam logic [2:0] OP_END   = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  localparam logic REG_TOP_ROW  = 1'b0;
  localparam logic REG_LINE_GAP = 1'b1;

  typedef enum logic [3:0] {
    CMD_NONE,      // idle
    CMD_LOAD,      // write font byte
    CMD_CLR_STEP,  // clear one frame byte at sweep counter
    CMD_CLR_DONE,  // reset cursor, flag and line
    CMD_CHAR_RD,   // read width byte of incoming char
    CMD_CHAR_ADD,  // append char and accumulate width
    CMD_OVF,       // set overflow flag
    CMD_READ,      // issue frame read
    CMD_FL_START,  // compute start x, reset char index
    CMD_FL_CODE,   // read buffered code
    CMD_FL_WIDTH,  // read glyph width byte
    CMD_FL_ROW,    // read glyph row byte for row index
    CMD_FL_RMW,    // read frame byte for current half
    CMD_FL_WRITE,  // write current half
    CMD_FL_NEXT,   // advance x and char index
    CMD_FL_DONE    // advance cursor, empty line
  } cmd_t;

  typedef struct packed {
    logic clr_last;    // sweep counter at last byte
    logic line_empty;  // no buffered chars
    logic line_full;   // buffer full
    logic chars_done;  // char index reached count
    logic glyph_ok;    // current code has a glyph
    logic row_last;    // row index at last row
    logic half_last;   // on second byte half
  } status_t;
endpackage

>>> hdl/centered_text_glyph_blitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// centered_text_glyph_blitter
// Centered proportional text engine on a 128x128 one-bit frame.
// ----------------------------------------------------------------------------
// Result: done strobes only for a read, registered in state S_READ.
// Clear sweeps the 2048-byte frame, one byte a cycle.
// Line draw: a row fetch and two frame byte RMWs per glyph row; codes without a glyph skip the rows.
// One transaction at a time; start is taken only while busy is low; no result stall.
// Synchronous reset: busy while the frame store is swept to zero.
module centered_text_glyph_blitter
  import ctgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode,
  input  logic [10:0] address,
  input  logic [7:0]  data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  output logic        done,
  output logic [7:0]  read_data,
  output logic        overflow_seen
);
  cmd_t    cmd;
  status_t status;

  ctgb_controller u_ctrl (
    .clk(clk), .rst(rst), .start(start), .opcode(opcode), .data(data),
    .status(status), .cmd(cmd), .busy(busy), .done(done)
  );

  ctgb_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .address(address), .data(data), .status(status),
    .read_data(read_data), .overflow_seen(overflow_seen)
  );
endmodule

>>> hdl/ctgb_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctgb_datapath
// Font, line and frame stores, cursors and pixel merge of the text blitter.
// ----------------------------------------------------------------------------
module ctgb_datapath
  import ctgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic [10:0] address,
  input  logic [7:0]  data,
  output status_t     status,
  output logic [7:0]  read_data,
  output logic        overflow_seen
);
  // memories
  logic [7:0] font_mem [FontBytes];
  logic [7:0] line_mem [LineChars];
  logic [7:0] frame_mem [FrameBytes];

  logic [6:0]  top_row;
  logic [3:0]  line_gap;
  logic [6:0]  line_count;
  logic [13:0] line_width;
  logic [7:0]  row_cursor;
  logic        overflow_flag;
  logic [10:0] clr_cnt;
  logic [10:0] in_addr;
  logic [7:0]  in_data;
  logic [7:0]  font_q;
  logic [7:0]  frame_q;
  logic        frame_oob;
  logic [6:0]  ch_idx;
  logic [7:0]  code;
  logic [13:0] xpos;
  logic [3:0]  row_idx;
  logic [7:0]  row_bits;
  logic [7:0]  gwidth;
  logic        half;
  logic [10:0] font_ra;
  logic [10:0] frame_ra;
  logic        font_rd_en;
  logic        frame_rd_en;

  // glyph test and base addresses
  logic        in_glyph;
  logic        cur_glyph;
  logic [10:0] in_base;
  logic [10:0] cur_base;
  logic [7:0]  in_off;
  logic [7:0]  cur_off;
  assign in_off    = in_data - 8'(FirstCode);
  assign cur_off   = code - 8'(FirstCode);
  assign in_glyph  = (in_data >= 8'(FirstCode)) && (in_off < 8'(NumGlyphs));
  assign cur_glyph = (code >= 8'(FirstCode)) && (cur_off < 8'(NumGlyphs));
  assign in_base   = 11'(in_off) * 11'(GlyphBytes);
  assign cur_base  = 11'(cur_off) * 11'(GlyphBytes);

  // pixel placement for the current half of the glyph row
  logic [14:0] px_col;
  logic [15:0] spread;
  logic [7:0]  half_bits;
  logic [8:0]  py;
  logic        col_ok;
  logic        row_ok;
  logic        set_any;
  assign spread    = {8'd0, row_bits} << xpos[2:0];
  assign half_bits = half ? spread[15:8] : spread[7:0];
  assign px_col    = {1'b0, xpos} + (half ? 15'd8 : 15'd0);
  assign py        = {1'b0, row_cursor} + 9'(row_idx);
  assign col_ok    = px_col < 15'(FrameDim);
  assign row_ok    = py < 9'(FrameDim);
  assign set_any   = half_bits != 8'd0;
  logic [10:0] wr_addr;
  assign wr_addr = 11'(py[6:0]) * 11'(RowBytes) + 11'(px_col[6:3]);

  always_comb begin
    font_rd_en  = 1'b0;
    frame_rd_en = 1'b0;
    font_ra     = '0;
    frame_ra    = '0;
    unique case (cmd)
      CMD_CHAR_RD: begin
        font_rd_en = 1'b1;
        font_ra    = in_base;
      end
      CMD_FL_WIDTH: begin
        font_rd_en = 1'b1;
        font_ra    = cur_base;
      end
      CMD_FL_ROW: begin
        font_rd_en = 1'b1;
        font_ra    = cur_base + 11'd1 + 11'(row_idx);
      end
      CMD_READ: begin
        frame_rd_en = 1'b1;
        frame_ra    = in_addr;
      end
      CMD_FL_RMW: begin
        frame_rd_en = 1'b1;
        frame_ra    = wr_addr;
      end
      default: begin
      end
    endcase
  end

  // font store
  always_ff @(posedge clk) begin
    if (cmd == CMD_LOAD && in_addr < 11'(FontBytes)) begin
      font_mem[in_addr] <= in_data;
    end
    if (font_rd_en) begin
      font_q <= font_mem[font_ra];
    end
  end

  // line buffer
  always_ff @(posedge clk) begin
    if (cmd == CMD_CHAR_ADD) begin
      line_mem[line_count[5:0]] <= in_data;
    end
  end

  // frame store
  always_ff @(posedge clk) begin
    if (cmd == CMD_CLR_STEP) begin
      frame_mem[clr_cnt] <= 8'd0;
    end else if (cmd == CMD_FL_WRITE && col_ok && row_ok) begin
      frame_mem[wr_addr] <= frame_q | half_bits;
    end
    if (frame_rd_en) begin
      frame_q <= frame_mem[frame_ra];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      top_row       <= 7'd3;
      line_gap      <= 4'd1;
      line_count    <= '0;
      line_width    <= '0;
      row_cursor    <= 8'd3;
      overflow_flag <= 1'b0;
      clr_cnt       <= '0;
      ch_idx        <= '0;
      row_idx       <= '0;
      half          <= 1'b0;
      xpos          <= '0;
      frame_oob     <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_TOP_ROW) begin
          top_row <= cfg_data;
        end else begin
          line_gap <= cfg_data[3:0];
        end
      end
      unique case (cmd)
        CMD_CLR_STEP: clr_cnt <= clr_cnt + 11'd1;
        CMD_CLR_DONE: begin
          clr_cnt       <= '0;
          row_cursor    <= {1'b0, top_row};
          overflow_flag <= 1'b0;
          line_count    <= '0;
          line_width    <= '0;
        end
        CMD_CHAR_ADD: begin
          logic [14:0] sum;
          sum = {1'b0, line_width} + (in_glyph ? 15'(font_q) : 15'd0);
          line_count <= line_count + 7'd1;
          line_width <= (sum > 15'(WidthMax)) ? 14'(WidthMax) : sum[13:0];
        end
        CMD_OVF: overflow_flag <= 1'b1;
        CMD_READ: frame_oob <= {1'b0, in_addr} >= 12'(FrameBytes);
        CMD_FL_START: begin
          ch_idx <= '0;
          xpos   <= (line_width <= 14'(FrameDim)) ? ((14'(FrameDim) - line_width) >> 1)
                                                   : 14'd0;
        end
        CMD_FL_WIDTH: begin
          row_idx <= '0;
          half    <= 1'b0;
        end
        CMD_FL_WRITE: begin
          if (set_any && !(col_ok && row_ok)) begin
            overflow_flag <= 1'b1;
          end
          if (half) begin
            half    <= 1'b0;
            row_idx <= row_idx + 4'd1;
          end else begin
            half <= 1'b1;
          end
        end
        CMD_FL_NEXT: begin
          logic [14:0] nx;
          nx = {1'b0, xpos} + (cur_glyph ? 15'(gwidth) : 15'd0);
          xpos   <= (nx > 15'(WidthMax)) ? 14'(WidthMax) : nx[13:0];
          ch_idx <= ch_idx + 7'd1;
        end
        CMD_FL_DONE: begin
          logic [8:0] nc;
          nc = {1'b0, row_cursor} + 9'(FontHeight) + 9'(line_gap);
          row_cursor <= (nc > 9'(CursorMax)) ? 8'(CursorMax) : nc[7:0];
          line_count <= '0;
          line_width <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // keep the glyph width aside; font_q carries the row bytes during the sweep
  always_ff @(posedge clk) begin
    if (cmd == CMD_FL_CODE) begin
      code <= line_mem[ch_idx[5:0]];
    end
    if (cmd == CMD_FL_RMW && !half) begin
      row_bits <= font_q;
    end
    if (cmd == CMD_FL_ROW && row_idx == 4'd0 && !half) begin
      gwidth <= font_q;
    end
  end

  // latch the item fields
  always_ff @(posedge clk) begin
    if (cmd == CMD_NONE) begin
      in_addr <= address;
      in_data <= data;
    end
  end

  assign read_data     = frame_oob ? 8'd0 : frame_q;
  assign overflow_seen = overflow_flag;

  assign status.clr_last   = clr_cnt == 11'(FrameBytes - 1);
  assign status.line_empty = line_count == 7'd0;
  assign status.line_full  = line_count >= 7'(LineChars);
  assign status.chars_done = ch_idx >= line_count;
  assign status.glyph_ok   = cur_glyph;
  assign status.row_last   = row_idx == 4'(FontHeight - 1);
  assign status.half_last  = half;
endmodule

>>> hdl/ctgb_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctgb_controller
// Command sequencer of the text blitter: one transaction at a time.
// ----------------------------------------------------------------------------
module ctgb_controller
  import ctgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [2:0] opcode,
  input  logic [7:0] data,
  input  status_t    status,
  output cmd_t       cmd,
  output logic       busy,
  output logic       done
);
  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_CLR, S_CLR_DONE, S_CHAR_RD, S_CHAR_ADD, S_OVF,
    S_READ, S_READ_OUT, S_FL_START, S_FL_CODE, S_FL_WIDTH, S_FL_ROW,
    S_FL_RMW, S_FL_WRITE, S_FL_NEXT
  } state_t;

  state_t state;
  logic   fl_done;

  // decode state into a datapath command
  always_comb begin
    unique case (state)
      S_IDLE:     cmd = CMD_NONE;
      S_LOAD:     cmd = CMD_LOAD;
      S_CLR:      cmd = CMD_CLR_STEP;
      S_CLR_DONE: cmd = CMD_CLR_DONE;
      S_CHAR_RD:  cmd = CMD_CHAR_RD;
      S_CHAR_ADD: cmd = CMD_CHAR_ADD;
      S_OVF:      cmd = CMD_OVF;
      S_READ:     cmd = CMD_READ;
      S_READ_OUT: cmd = CMD_NONE;
      S_FL_START: cmd = CMD_FL_START;
      S_FL_CODE:  cmd = fl_done ? CMD_FL_DONE : CMD_FL_CODE;
      S_FL_WIDTH: cmd = CMD_FL_WIDTH;
      S_FL_ROW:   cmd = CMD_FL_ROW;
      S_FL_RMW:   cmd = CMD_FL_RMW;
      S_FL_WRITE: cmd = CMD_FL_WRITE;
      S_FL_NEXT:  cmd = CMD_FL_NEXT;
      default:    cmd = CMD_NONE;
    endcase
  end
  assign fl_done = status.chars_done;
  assign busy    = state != S_IDLE;

  // hold state and the result strobe; sweep the frame after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            unique case (opcode)
              OP_LOAD:  state <= S_LOAD;
              OP_CLEAR: state <= S_CLR;
              OP_CHAR: begin
                if (data == 8'(NewlineCode)) begin
                  state <= S_FL_START;
                end else begin
                  state <= S_CHAR_RD;
                end
              end
              OP_END:   state <= status.line_empty ? S_IDLE : S_FL_START;
              OP_READ:  state <= S_READ;
              default:  state <= S_IDLE;
            endcase
          end
        end
        S_LOAD:     state <= S_IDLE;
        S_CLR:      state <= status.clr_last ? S_CLR_DONE : S_CLR;
        S_CLR_DONE: state <= S_IDLE;
        S_CHAR_RD:  state <= status.line_full ? S_OVF : S_CHAR_ADD;
        S_CHAR_ADD: state <= S_IDLE;
        S_OVF:      state <= S_IDLE;
        S_READ: begin
          state <= S_READ_OUT;
          done  <= 1'b1;
        end
        S_READ_OUT: state <= S_IDLE;
        S_FL_START: state <= S_FL_CODE;
        S_FL_CODE:  state <= fl_done ? S_IDLE : S_FL_WIDTH;
        S_FL_WIDTH: state <= S_FL_ROW;
        S_FL_ROW:   state <= status.glyph_ok ? S_FL_RMW : S_FL_NEXT;
        S_FL_RMW:   state <= S_FL_WRITE;
        S_FL_WRITE: begin
          if (!status.half_last) begin
            state <= S_FL_RMW;
          end else if (status.row_last) begin
            state <= S_FL_NEXT;
          end else begin
            state <= S_FL_ROW;
          end
        end
        S_FL_NEXT:  state <= S_FL_CODE;
        default:    state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> hdl/ctgb_checker.sv
`timescale 1ns / 1ps
`include "centered_text_glyph_blitter_defines.svh"
// ----------------------------------------------------------------------------
// ctgb_checker
// Port-level checks of the text blitter, bound to the top level.
// ----------------------------------------------------------------------------
module ctgb_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);
  `CTGB_ASSERT_NEVER(a_done_idle, clk, rst, done && !busy, "result strobe while idle")
  `CTGB_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done, "result strobe longer than one cycle")
  `CTGB_ASSERT_NEXT(a_done_release, clk, rst, done, !busy, "busy held after result")

  logic unused;
  assign unused = start;
endmodule

bind centered_text_glyph_blitter ctgb_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done)
);
